@@ sv/swmc_pkg.sv @@
// Shared types and constants for the sliding-window maximum charge block.
package swmc_pkg;

  localparam int TIME_W   = 32;
  localparam int CHARGE_W = 24;
  localparam int SUM_W    = 40;
  localparam int OUT_W    = 31;

  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MAX = 40'sh7F_FFFF_FFFF;
  localparam sum_t SUM_MIN = 40'sh80_0000_0000;
  localparam sum_t OUT_MAX = 40'sh00_7FFF_FFFF;

  typedef struct packed {
    logic [TIME_W-1:0]          pulse_time;
    logic signed [CHARGE_W-1:0] pulse_charge;
    logic                       last_pulse;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] max_charge;
    logic             overflow;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_ADD,
    S_DRAIN_FETCH,
    S_DRAIN,
    S_LAST_CMP,
    S_EMIT
  } state_t;

endpackage

@@ sv/swmc_queue.sv @@
// Pulse queue storage: time and charge memories, one write and one registered read port.
module swmc_queue #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [AW-1:0]                         waddr,
  input  logic [swmc_pkg::TIME_W-1:0]           wtime,
  input  logic signed [swmc_pkg::CHARGE_W-1:0]  wcharge,
  input  logic [AW-1:0]                         raddr,
  output logic [swmc_pkg::TIME_W-1:0]           rtime,
  output logic signed [swmc_pkg::CHARGE_W-1:0]  rcharge
);
  import swmc_pkg::*;

  logic [TIME_W-1:0]          time_mem [DEPTH];
  logic signed [CHARGE_W-1:0] charge_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr]   <= wtime;
      charge_mem[waddr] <= wcharge;
    end
  end

  always_ff @(posedge clk) begin
    rtime   <= time_mem[raddr];
    rcharge <= charge_mem[raddr];
  end

endmodule

@@ sv/swmc_sat_add.sv @@
// Shared 40-bit saturating adder for the running window sum.
module swmc_sat_add (
  input  swmc_pkg::sum_t a,
  input  swmc_pkg::sum_t b,
  output swmc_pkg::sum_t y,
  output logic           sat
);
  import swmc_pkg::*;

  logic signed [SUM_W:0] s;

  always_comb begin
    s   = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    sat = s[SUM_W] != s[SUM_W-1];
    if (!sat) begin
      y = s[SUM_W-1:0];
    end else if (s[SUM_W]) begin
      y = SUM_MIN;
    end else begin
      y = SUM_MAX;
    end
  end

endmodule

@@ sv/sliding_window_max_charge_top.sv @@
// Sliding-window maximum charge: top level with sequencer, queue and shared adder.
//
// Input channel in_valid/in_ready/in_data carries one pulse word (time, charge,
// last-pulse mark). Output channel out_valid/out_ready/out_data carries one
// result word (max_charge, overflow) after each pulse marked last; other pulses
// give no result. Write window_length (cfg_we/cfg_wdata) only while idle; the block does not check.
//
// A pulse word with window_length zero goes straight to the add step; otherwise
// the oldest queued window is fetched and checked, and each one closed because
// its time ran out is a queue read plus one pass through the shared saturating
// adder; a full queue closes its oldest window early in the check step itself.
// A last pulse then drains every queued window, or makes a final compare if none
// is queued, and hands the result over. It is not ready while a word is in work.
//
// A synchronous reset clears window_length, the queue pointers, the sums and
// the result valid flag; queue memory is not cleared. A finished result sits in
// the output register; the next pulse words are still taken, and the block
// holds only when another result is ready while the previous one waits.
module sliding_window_max_charge_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  swmc_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output swmc_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [swmc_pkg::TIME_W-1:0]    cfg_wdata
);
  import swmc_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;

  logic [TIME_W-1:0] wl;
  in_t               pulse;
  logic [AW-1:0]     head;
  logic [CW-1:0]     count;
  sum_t              window_sum;
  sum_t              best_sum;
  logic              ovf_seen;

  logic [TIME_W-1:0]          rd_time;
  logic signed [CHARGE_W-1:0] rd_charge;

  logic          empty, full, wl_zero, time_close;
  logic [TIME_W:0] diff;
  logic [AW-1:0] head_inc, slot;
  logic [AW:0]   slot_wide;
  sum_t          alu_b, alu_y;
  logic          alu_sat;

  logic close_en, full_ovf, add_en, push_en, last_cmp, emit;

  assign empty   = count == '0;
  assign full    = count == CW'(QUEUE_DEPTH);
  assign wl_zero = wl == '0;

  // Signed difference: a negative gap never closes a window.
  assign diff       = {1'b0, pulse.pulse_time} - {1'b0, rd_time};
  assign time_close = !diff[TIME_W] && (diff[TIME_W-1:0] >= wl);

  assign head_inc  = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign slot_wide = (AW+1)'(head) + (AW+1)'(count);
  assign slot      = (slot_wide >= (AW+1)'(QUEUE_DEPTH)) ?
                     AW'(slot_wide - (AW+1)'(QUEUE_DEPTH)) : slot_wide[AW-1:0];

  swmc_queue #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_queue (
    .clk     (clk),
    .we      (push_en),
    .waddr   (slot),
    .wtime   (pulse.pulse_time),
    .wcharge (pulse.pulse_charge),
    .raddr   (head),
    .rtime   (rd_time),
    .rcharge (rd_charge)
  );

  // Add the new charge, or subtract the oldest one on a close.
  assign alu_b = add_en ? {{(SUM_W-CHARGE_W){pulse.pulse_charge[CHARGE_W-1]}}, pulse.pulse_charge}
                        : -{{(SUM_W-CHARGE_W){rd_charge[CHARGE_W-1]}}, rd_charge};

  swmc_sat_add u_add (
    .a   (window_sum),
    .b   (alu_b),
    .y   (alu_y),
    .sat (alu_sat)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = wl_zero ? S_ADD : S_FETCH;
      end
      S_FETCH:       state_next = S_CHECK;
      S_CHECK: begin
        if (!empty && time_close) state_next = S_FETCH;
        else                      state_next = S_ADD;
      end
      S_ADD: begin
        if (!pulse.last_pulse)         state_next = S_IDLE;
        else if (!wl_zero || !empty)   state_next = S_DRAIN_FETCH;
        else                           state_next = S_LAST_CMP;
      end
      S_DRAIN_FETCH: state_next = S_DRAIN;
      S_DRAIN: begin
        state_next = (count == CW'(1)) ? S_EMIT : S_DRAIN_FETCH;
      end
      S_LAST_CMP:    state_next = S_EMIT;
      S_EMIT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default:       state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state == S_IDLE;
    close_en = (state == S_CHECK && !empty && (time_close || full)) || state == S_DRAIN;
    full_ovf = state == S_CHECK && full && !time_close;
    add_en   = state == S_ADD;
    push_en  = state == S_ADD && !wl_zero;
    last_cmp = state == S_LAST_CMP;
    emit     = state == S_EMIT && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wl         <= '0;
      head       <= '0;
      count      <= '0;
      window_sum <= '0;
      best_sum   <= '0;
      ovf_seen   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) wl <= cfg_wdata;

      if (close_en || add_en) window_sum <= alu_y;
      if (((close_en || add_en) && alu_sat) || full_ovf) ovf_seen <= 1'b1;

      if (close_en || last_cmp) begin
        if (window_sum > best_sum) best_sum <= window_sum;
      end

      if (close_en) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end else if (push_en) begin
        count <= count + 1'b1;
      end

      if (emit) begin
        out_valid  <= 1'b1;
        head       <= '0;
        count      <= '0;
        window_sum <= '0;
        best_sum   <= '0;
        ovf_seen   <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the pulse word for the whole sequence; latch the result on handover.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) pulse <= in_data;
    if (emit) begin
      if (best_sum > OUT_MAX) begin
        out_data.max_charge <= '1;
        out_data.overflow   <= 1'b1;
      end else begin
        out_data.max_charge <= best_sum[OUT_W-1:0];
        out_data.overflow   <= ovf_seen;
      end
    end
  end

endmodule

@@ sv/swmc_checker.sv @@
// Port-level checks for the sliding-window maximum charge block, bound to the top level.
module swmc_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input swmc_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input swmc_pkg::out_t out_data
);
  import swmc_pkg::*;

  // Busy in the cycle right after taking a pulse word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted word");

  // A pulse that is not last never raises a result on the next cycle.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.last_pulse |=> !$rose(out_valid))
    else $error("result raised after a non-last pulse");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_max_charge_top swmc_checker u_swmc_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the sliding-window maximum charge block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import swmc_pkg::*;

  localparam int DEPTH = 64;
  localparam int RAND_ITEMS = 430;
  localparam int SAT_LEN = 300;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;

  localparam logic [CHARGE_W-1:0] CHARGE_TOP = 24'h7F_FFFF;
  localparam logic [CHARGE_W-1:0] CHARGE_BOTTOM = 24'h80_0000;
  localparam logic [TIME_W-1:0] TIME_TOP = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [TIME_W-1:0] cfg_wdata = '0;

  sliding_window_max_charge_top #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pulse words waiting to be sent and max-charge results waiting to arrive
  in_t pulse_q[$];
  out_t expected_results[$];

  int unsigned pushed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned series_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned fails = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit word_in_taken = 1'b0;
  bit word_out_taken = 1'b0;
  bit steady = 1'b0;

  // Predictor state: open windows, running sum and best sum
  logic [TIME_W-1:0] win_len = '0;
  logic [TIME_W-1:0] pend_time[DEPTH];
  logic signed [CHARGE_W-1:0] pend_charge[DEPTH];
  int unsigned pend_head = 0;
  int unsigned pend_count = 0;
  sum_t run_sum = '0;
  sum_t best_sum = '0;
  bit ovf_seen = 1'b0;

  function automatic int unsigned draw_wait();
    if (steady) return 0;
    return $urandom_range(0, 5);
  endfunction

  function automatic void add_to_sum(longint v);
    longint s;
    s = longint'(run_sum) + v;
    if (s > longint'(SUM_MAX)) begin
      s = longint'(SUM_MAX);
      ovf_seen = 1'b1;
    end else if (s < longint'(SUM_MIN)) begin
      s = longint'(SUM_MIN);
      ovf_seen = 1'b1;
    end
    run_sum = sum_t'(s);
  endfunction

  function automatic void retire_oldest();
    if (run_sum > best_sum) best_sum = run_sum;
    add_to_sum(-longint'(pend_charge[pend_head]));
    pend_head = (pend_head + 1) % DEPTH;
    pend_count--;
  endfunction

  function automatic void fold_pulse(in_t p);
    int unsigned slot;
    bit ovf;
    out_t r;
    if (win_len != 0) begin
      // close windows whose start lies a full window length behind this pulse
      while (pend_count > 0 &&
             longint'({32'd0, p.pulse_time}) - longint'({32'd0, pend_time[pend_head]}) >=
             longint'({32'd0, win_len}))
        retire_oldest();
      if (pend_count >= DEPTH) begin
        retire_oldest();
        ovf_seen = 1'b1;
      end
      slot = (pend_head + pend_count) % DEPTH;
      pend_time[slot] = p.pulse_time;
      pend_charge[slot] = p.pulse_charge;
      pend_count++;
    end
    add_to_sum(longint'(p.pulse_charge));
    if (!p.last_pulse) return;
    if (pend_count == 0) begin
      if (run_sum > best_sum) best_sum = run_sum;
    end else begin
      while (pend_count > 0) retire_oldest();
    end
    ovf = ovf_seen;
    if (best_sum > OUT_MAX) begin
      r.max_charge = OUT_MAX[OUT_W-1:0];
      ovf = 1'b1;
    end else begin
      r.max_charge = best_sum[OUT_W-1:0];
    end
    r.overflow = ovf;
    expected_results = {expected_results, r};
    pend_head = 0;
    pend_count = 0;
    run_sum = '0;
    best_sum = '0;
    ovf_seen = 1'b0;
  endfunction

  // Monitor: check result words, fold accepted pulse words, watch for stalls
  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        word_out_taken = 1'b1;
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result word with none pending: max_charge=%0d overflow=%0b",
                 out_data.max_charge, out_data.overflow);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.max_charge !== want.max_charge) begin
            $error("max_charge: expected %0d, got %0d", want.max_charge, out_data.max_charge);
            fails++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        word_in_taken = 1'b1;
        accepted_cnt++;
        if (in_data.last_pulse) series_cnt++;
        fold_pulse(in_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Stall: no word moved for %0d cycles, %0d pulse words still pending",
                 quiet_cycles, pushed_cnt - accepted_cnt);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Driver: send pulse words, throttle the result side
  always @(negedge clk) begin
    logic v_next;
    logic r_next;
    if (!rst) begin
      v_next = in_valid;
      if (word_in_taken) begin
        word_in_taken = 1'b0;
        v_next = 1'b0;
        in_gap = draw_wait();
      end
      if (!v_next && pulse_q.size() > 0) begin
        if (in_gap == 0) begin
          in_data <= pulse_q.pop_front();
          v_next = 1'b1;
        end else begin
          in_gap--;
        end
      end
      in_valid <= v_next;

      r_next = out_ready;
      if (word_out_taken) begin
        word_out_taken = 1'b0;
        out_gap = draw_wait();
        r_next = (out_gap == 0);
      end else if (!out_ready) begin
        if (out_gap == 0) r_next = 1'b1;
        else out_gap--;
      end
      out_ready <= r_next;
    end
  end

  function automatic void add_pulse(logic [TIME_W-1:0] t, logic [CHARGE_W-1:0] c, bit last);
    in_t p;
    p.pulse_time = t;
    p.pulse_charge = c;
    p.last_pulse = last;
    pulse_q = {pulse_q, p};
    pushed_cnt++;
  endfunction

  task automatic settle();
    while (!(accepted_cnt == pushed_cnt && expected_results.size() == 0)) @(posedge clk);
    // a pulse that gives no result may still be draining inside the block
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(logic [TIME_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    win_len = v;
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  int unsigned win_kind = 0;
  bit want_long = 1'b0;

  task automatic next_window();
    logic [TIME_W-1:0] v;
    case (win_kind % 6)
      0: v = '0;
      1: v = 32'd1;
      2: begin
        v = TIME_TOP;
        want_long = 1'b1;
      end
      3: v = $urandom_range(2, 64);
      4: v = $urandom_range(65, 100000);
      default: v = $urandom();
    endcase
    win_kind++;
    steady = ($urandom_range(0, 3) == 0);
    write_window(v);
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned next_switch;
    int unsigned len;
    int unsigned step_max;
    int unsigned pick;
    logic [TIME_W-1:0] t;
    logic [CHARGE_W-1:0] c;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // whole-series window, charge extremes, time extremes
    write_window('0);
    add_pulse('0, CHARGE_TOP, 1'b0);
    add_pulse(32'd7, CHARGE_BOTTOM, 1'b0);
    add_pulse(TIME_TOP, 24'h000100, 1'b1);
    add_pulse(32'd50, -24'sd300, 1'b1);

    // shortest window: only equal times share a window
    write_window(32'd1);
    add_pulse(32'd10, 24'd500, 1'b0);
    add_pulse(32'd10, 24'd700, 1'b0);
    add_pulse(32'd11, -24'sd100, 1'b0);
    add_pulse(32'd11, 24'd300, 1'b1);

    // longest window, with a full-range time step
    write_window(TIME_TOP);
    add_pulse('0, 24'd1000, 1'b0);
    add_pulse(TIME_TOP, 24'd2000, 1'b1);

    // time going backward never closes a window
    write_window(32'd20);
    add_pulse(32'd100, 24'd400, 1'b0);
    add_pulse(32'd90, 24'd600, 1'b0);
    add_pulse(32'd95, -24'sd50, 1'b0);
    add_pulse(32'd130, 24'd250, 1'b1);

    // change the window length in the middle of a series
    write_window(32'd50);
    add_pulse(32'd1000, 24'd800, 1'b0);
    add_pulse(32'd1010, -24'sd200, 1'b0);
    write_window('0);
    add_pulse(32'd1020, 24'd900, 1'b0);
    write_window(32'd3);
    add_pulse(32'd1040, 24'd100, 1'b1);

    // random series under a rotating set of window lengths
    rand_items = 0;
    next_switch = 50;
    win_kind = 2;
    next_window();
    while (rand_items < RAND_ITEMS) begin
      if (want_long) begin
        len = $urandom_range(65, 90);
        want_long = 1'b0;
      end else begin
        len = $urandom_range(1, 12);
      end
      if (win_len == 0) step_max = 64;
      else if (win_len > 32'h0010_0000) step_max = 32'h0004_0000;
      else step_max = win_len / 2 + 1;
      t = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1000);
      for (int unsigned k = 0; k < len; k++) begin
        pick = $urandom_range(0, 31);
        if (k == 0) t = t;
        else if (pick == 0) t = $urandom();
        else if (pick == 1) t = t - $urandom_range(1, 40);
        else if (pick < 6) t = t;
        else t = t + $urandom_range(0, step_max);
        pick = $urandom_range(0, 19);
        if (pick == 0) c = CHARGE_TOP;
        else if (pick == 1) c = CHARGE_BOTTOM;
        else if (pick < 5) c = CHARGE_W'($urandom());
        else c = CHARGE_W'($urandom_range(0, 6000)) - 24'd2000;
        add_pulse(t, c, k == len - 1);
        rand_items++;
        if (k != len - 1 && $urandom_range(0, 40) == 0) next_window();
      end
      if (rand_items >= next_switch) begin
        next_window();
        next_switch += 50;
      end
    end

    // push the reported maximum past its clamp under a whole-series window
    write_window('0);
    steady = 1'b1;
    for (int unsigned k = 0; k < SAT_LEN; k++) add_pulse(k, CHARGE_TOP, k == SAT_LEN - 1);

    while (!(accepted_cnt == pushed_cnt && expected_results.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d pulse words in %0d series (one of %0d full-charge words clamps the maximum),",
             accepted_cnt, series_cnt, SAT_LEN);
    $display("checked %0d result words over %0d window length writes", results_seen, cfg_writes);
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sliding_window_max_charge_top.f @@
sv/swmc_pkg.sv
sv/swmc_queue.sv
sv/swmc_sat_add.sv
sv/sliding_window_max_charge_top.sv
sv/swmc_checker.sv
tb/testbench.sv
